// ===== rtl/core/psh_pkg.sv =====
// Shared types and constants for the position servo with homing.
`default_nettype none

package psh_pkg;

  localparam int DataW    = 32;
  localparam int EsumW    = 15;
  localparam int ClampW   = 31;
  localparam int CmdW     = 3;
  localparam int CfgIdxW  = 3;
  localparam int InDataW  = 96;
  localparam int OutDataW = 136;

  localparam logic signed [EsumW-1:0] IntegralLimit = 15'sd16383;
  localparam logic [DataW-1:0]  HomingDrive    = 32'hffff_ffc0;
  localparam logic [DataW-1:0]  KpReset        = 32'h0001_0000;
  localparam logic [DataW-1:0]  KiReset        = 32'h0000_0200;
  localparam logic [DataW-1:0]  KdReset        = 32'h0001_0000;
  localparam logic [ClampW-1:0] DrvLimitReset  = 31'h100;
  localparam logic [ClampW-1:0] MaxRangeReset  = 31'h600;
  localparam logic [DataW-1:0]  HomeMaskReset  = 32'h1;
  localparam logic [DataW-1:0]  TravelLimReset = 32'h600;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ENABLE  = 3'd1,
    CMD_DISABLE = 3'd2,
    CMD_JUMP    = 3'd3,
    CMD_HOME    = 3'd4
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP        = 3'd0,
    REG_KI        = 3'd1,
    REG_KD        = 3'd2,
    REG_DRV_LIMIT = 3'd3,
    REG_MAX_RANGE = 3'd4,
    REG_HOME_MASK = 3'd5
  } cfg_idx_t;

  // what the drive does for one request
  typedef enum logic [1:0] {
    DRV_KEEP   = 2'd0,
    DRV_ZERO   = 2'd1,
    DRV_HOMING = 2'd2,
    DRV_PID    = 2'd3
  } drv_act_t;

  typedef struct packed {
    logic             valid;
    drv_act_t         act;
    logic [DataW-1:0] err;
    logic [EsumW-1:0] esum;
    logic [DataW-1:0] derr;
  } pid_req_t;

  typedef struct packed {
    logic             en;
    logic             at_home;
    logic             homing;
    logic [DataW-1:0] abs_pos;
    logic [DataW-1:0] rel_pos;
    logic [DataW-1:0] speed;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/psh_pid.sv =====
// PID product stage and drive register with output clamp.
`default_nettype none

module psh_pid import psh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  pid_req_t          req,
  input  logic [DataW-1:0]  kp,
  input  logic [DataW-1:0]  ki,
  input  logic [DataW-1:0]  kd,
  input  logic [ClampW-1:0] drv_limit,
  output logic [DataW-1:0]  drive
);

  logic             p_valid_r;
  drv_act_t         p_act_r;
  logic [DataW-1:0] pk_r;
  logic [DataW-1:0] pi_r;
  logic [DataW-1:0] pd_r;
  logic [DataW-1:0] drive_r;
  logic [DataW-1:0] drive_nxt;

  logic [DataW-1:0]        esum_ext;
  logic [DataW-1:0]        acc;
  logic signed [DataW-1:0] shifted;
  logic signed [DataW:0]   sh_w;
  logic signed [DataW:0]   lim_w;
  logic signed [DataW:0]   nlim_w;
  logic signed [DataW:0]   clamped;

  assign esum_ext = {{(DataW-EsumW){req.esum[EsumW-1]}}, req.esum};

  // low 32 bits of each product, as the wrapping arithmetic wants
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r <= req.valid;
    end
    if (adv) begin
      p_act_r <= req.act;
      pk_r    <= kp * req.err;
      pi_r    <= ki * esum_ext;
      pd_r    <= kd * req.derr;
    end
  end

  always_comb begin
    acc     = pk_r + pi_r + pd_r;
    shifted = $signed(acc) >>> 16;
    sh_w    = {shifted[DataW-1], shifted};
    lim_w   = $signed({2'b00, drv_limit});
    nlim_w  = -lim_w;
    if (sh_w > lim_w) begin
      clamped = lim_w;
    end else if (sh_w < nlim_w) begin
      clamped = nlim_w;
    end else begin
      clamped = sh_w;
    end
  end

  always_comb begin
    drive_nxt = drive_r;
    case (p_act_r)
      DRV_KEEP:   drive_nxt = drive_r;
      DRV_ZERO:   drive_nxt = '0;
      DRV_HOMING: drive_nxt = HomingDrive;
      DRV_PID:    drive_nxt = clamped[DataW-1:0];
      default:    drive_nxt = drive_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= '0;
    end else if (adv && p_valid_r) begin
      drive_r <= drive_nxt;
    end
  end

  assign drive = drive_r;

endmodule

`default_nettype wire

// ===== rtl/core/pid_position_servo_with_homing.sv =====
// Top level of the PID position servo with homing.
// Pipeline: an accepted request passes the state update, the product register and the output
// register on its way to out_tvalid. Throughput: one request per cycle unless out_tready
// stalls the result channel; the state update closes within its own stage, the three gain
// multiplies and the clamp sit in later stages and only feed the drive register.
// Reset (rst_n low, synchronous) restores gains and limits, clears servo state and empties
// the pipeline; the block takes requests as soon as reset is released.
`default_nettype none

module pid_position_servo_with_homing import psh_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [CmdW-1:0]     in_tuser,   // command
  input  logic [InDataW-1:0]  in_tdata,   // encoder_position, switch_word, rel_target
  output logic                out_tvalid,
  input  logic                out_tready,
  // motor_drive, loop_enabled, at_home, homing_pending, abs_position, rel_position,
  // speed_estimate, zero pad
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_wen,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [DataW-1:0]    cfg_wdata
);

  logic              adv;

  logic [DataW-1:0]  kp_r, ki_r, kd_r, home_mask_r;
  logic [ClampW-1:0] drv_limit_r, max_range_r;

  logic              s0_valid_r;
  logic [CmdW-1:0]   s0_cmd_r;
  logic [DataW-1:0]  s0_enc_r, s0_sw_r, s0_rel_r;

  logic [DataW-1:0]  position_r, prev_err_r, target_r, home_r, limit_r, speed_r;
  logic [EsumW-1:0]  esum_r;
  logic              enabled_r, home_level_r, homing_r;
  logic [DataW-1:0]  position_nxt, prev_err_nxt, target_nxt, home_nxt, limit_nxt, speed_nxt;
  logic [EsumW-1:0]  esum_nxt;
  logic              enabled_nxt, home_level_nxt, homing_nxt;

  logic [DataW-1:0]  err, derr;
  logic signed [DataW:0] sum_w;
  logic [EsumW-1:0]  esum_sat;
  logic              home_now, home_edge, en_tmp;
  drv_act_t          act;

  pid_req_t          s1_req_r;
  stat_t             s1_stat_r, s2_stat_r, out_stat_r;
  logic              s2_valid_r, out_valid_r;
  logic [DataW-1:0]  drive;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= KpReset;
      ki_r        <= KiReset;
      kd_r        <= KdReset;
      drv_limit_r <= DrvLimitReset;
      max_range_r <= MaxRangeReset;
      home_mask_r <= HomeMaskReset;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_KP:        kp_r        <= cfg_wdata;
        REG_KI:        ki_r        <= cfg_wdata;
        REG_KD:        kd_r        <= cfg_wdata;
        REG_DRV_LIMIT: drv_limit_r <= cfg_wdata[ClampW-1:0];
        REG_MAX_RANGE: max_range_r <= cfg_wdata[ClampW-1:0];
        REG_HOME_MASK: home_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_tvalid;
    end
    if (adv) begin
      s0_cmd_r <= in_tuser;
      s0_enc_r <= in_tdata[31:0];
      s0_sw_r  <= in_tdata[63:32];
      s0_rel_r <= in_tdata[95:64];
    end
  end

  // error terms use the fresh encoder sample
  always_comb begin
    err   = target_r - s0_enc_r;
    derr  = err - prev_err_r;
    sum_w = $signed({{(DataW+1-EsumW){esum_r[EsumW-1]}}, esum_r})
          + $signed({err[DataW-1], err});
    if (sum_w > $signed({{(DataW+1-EsumW){1'b0}}, IntegralLimit})) begin
      esum_sat = IntegralLimit;
    end else if (sum_w < -$signed({{(DataW+1-EsumW){1'b0}}, IntegralLimit})) begin
      esum_sat = -IntegralLimit;
    end else begin
      esum_sat = sum_w[EsumW-1:0];
    end
    home_now  = |(s0_sw_r & home_mask_r);
    home_edge = !home_level_r && home_now;
  end

  always_comb begin
    position_nxt   = position_r;
    prev_err_nxt   = prev_err_r;
    target_nxt     = target_r;
    home_nxt       = home_r;
    limit_nxt      = limit_r;
    speed_nxt      = speed_r;
    esum_nxt       = esum_r;
    enabled_nxt    = enabled_r;
    home_level_nxt = home_level_r;
    homing_nxt     = homing_r;
    en_tmp         = enabled_r;
    act            = DRV_KEEP;
    case (s0_cmd_r)
      CMD_TICK: begin
        speed_nxt    = s0_enc_r - position_r;
        position_nxt = s0_enc_r;
        if (enabled_r) begin
          esum_nxt     = esum_sat;
          prev_err_nxt = err;
          act          = DRV_PID;
        end else begin
          esum_nxt = '0;
        end
        home_level_nxt = home_now;
        if (home_edge) begin
          en_tmp = 1'b0;
          act    = DRV_ZERO;
          if (homing_r) begin
            homing_nxt = 1'b0;
            home_nxt   = s0_enc_r;
            target_nxt = s0_enc_r;
            limit_nxt  = s0_enc_r + {1'b0, max_range_r};
          end
        end
        // past the travel limit: shut down
        if (en_tmp && ($signed(s0_enc_r) > $signed(limit_r))) begin
          en_tmp = 1'b0;
          act    = DRV_ZERO;
        end
        enabled_nxt = en_tmp;
      end
      CMD_ENABLE: begin
        act         = DRV_ZERO;
        enabled_nxt = 1'b1;
      end
      CMD_DISABLE: begin
        act         = DRV_ZERO;
        enabled_nxt = 1'b0;
      end
      CMD_JUMP: begin
        if (enabled_r) begin
          target_nxt = s0_rel_r + home_r;
        end
      end
      CMD_HOME: begin
        act         = DRV_HOMING;
        enabled_nxt = 1'b0;
        homing_nxt  = 1'b1;
      end
      default: ;
    endcase
  end

  // servo state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      prev_err_r   <= '0;
      target_r     <= '0;
      home_r       <= '0;
      limit_r      <= TravelLimReset;
      speed_r      <= '0;
      esum_r       <= '0;
      enabled_r    <= 1'b0;
      home_level_r <= 1'b0;
      homing_r     <= 1'b0;
    end else if (adv && s0_valid_r) begin
      position_r   <= position_nxt;
      prev_err_r   <= prev_err_nxt;
      target_r     <= target_nxt;
      home_r       <= home_nxt;
      limit_r      <= limit_nxt;
      speed_r      <= speed_nxt;
      esum_r       <= esum_nxt;
      enabled_r    <= enabled_nxt;
      home_level_r <= home_level_nxt;
      homing_r     <= homing_nxt;
    end
  end

  // pipeline behind the state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_req_r.valid <= 1'b0;
      s2_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else if (adv) begin
      s1_req_r.valid <= s0_valid_r;
      s2_valid_r     <= s1_req_r.valid;
      out_valid_r    <= s2_valid_r;
    end
    if (adv) begin
      s1_req_r.act       <= act;
      s1_req_r.err       <= err;
      s1_req_r.esum      <= esum_sat;
      s1_req_r.derr      <= derr;
      s1_stat_r.en       <= enabled_nxt;
      s1_stat_r.at_home  <= home_level_nxt;
      s1_stat_r.homing   <= homing_nxt;
      s1_stat_r.abs_pos  <= position_nxt;
      s1_stat_r.rel_pos  <= position_nxt - home_nxt;
      s1_stat_r.speed    <= speed_nxt;
      s2_stat_r          <= s1_stat_r;
      out_stat_r         <= s2_stat_r;
    end
  end

  psh_pid u_pid (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .req       (s1_req_r),
    .kp        (kp_r),
    .ki        (ki_r),
    .kd        (kd_r),
    .drv_limit (drv_limit_r),
    .drive     (drive)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_stat_r.speed, out_stat_r.rel_pos, out_stat_r.abs_pos,
                       out_stat_r.homing, out_stat_r.at_home, out_stat_r.en, drive};

  a_esum_range: assert property (@(posedge clk) disable iff (!rst_n)
    esum_r != 15'h4000)
    else $error("integral sum left its saturation range");

  a_s0_moves: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s0_valid_r |=> s1_req_r.valid)
    else $error("request lost between input register and state stage");

  a_home_edge_off: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s0_valid_r && (s0_cmd_r == CMD_TICK) && home_edge |=> !enabled_r)
    else $error("loop still enabled after home switch edge");

endmodule

`default_nettype wire

// ===== bench/pid_position_servo_with_homing_tb.sv =====
// Self-checking testbench for the PID position servo with homing: queued stimulus, random stalls.
module pid_position_servo_with_homing_tb;
  import psh_pkg::*;

  // command codes the block treats as no-ops
  localparam logic [CmdW-1:0] CMD_RSV5 = 3'd5;
  localparam logic [CmdW-1:0] CMD_RSV6 = 3'd6;
  localparam logic [CmdW-1:0] CMD_RSV7 = 3'd7;

  localparam int IdlePct     = 26;
  localparam int DrainCycles = 12;
  localparam int NFields     = 7;

  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] enc;
    logic [DataW-1:0] sw;
    logic [DataW-1:0] rel;
  } servo_cmd_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  wire                 in_tready;
  logic [CmdW-1:0]     in_tuser   = '0;
  logic [InDataW-1:0]  in_tdata   = '0;
  wire                 out_tvalid;
  logic                out_tready = 1'b0;
  wire  [OutDataW-1:0] out_tdata;
  logic                cfg_wen    = 1'b0;
  cfg_idx_t            cfg_index  = REG_KP;
  logic [DataW-1:0]    cfg_wdata  = '0;

  pid_position_servo_with_homing dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // servo model: gains, limits and loop state
  logic [DataW-1:0]  gain_kp, gain_ki, gain_kd, home_bits;
  logic [ClampW-1:0] drive_lim, range_lim;
  logic [DataW-1:0]  srv_pos, srv_prev_err, srv_tgt, srv_home, srv_limit, srv_drive, srv_speed;
  int                srv_esum;
  logic              srv_en, srv_hlev, srv_homing;

  servo_cmd_t          pending_q [$];
  logic [OutDataW-1:0] status_exp_q [$];
  servo_cmd_t          drv_req;
  logic [OutDataW-1:0] want_bits, got_bits;
  logic [DataW-1:0]    stim_mask;
  logic                req_taken  = 1'b0;
  logic                no_idle    = 1'b0;
  int                  mismatches = 0;
  int                  results_seen = 0;
  int                  queued     = 0;

  // result fields, lowest bit up
  int          field_lsb  [NFields] = '{0, 32, 33, 34, 35, 67, 99};
  logic [31:0] field_mask [NFields] = '{32'hffff_ffff, 32'h1, 32'h1, 32'h1,
                                        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
  string       field_name [NFields] = '{"motor_drive", "loop_enabled", "at_home",
                                        "homing_pending", "abs_position", "rel_position",
                                        "speed_estimate"};

  function automatic void reset_servo_model();
    gain_kp = KpReset;  gain_ki = KiReset;  gain_kd = KdReset;
    drive_lim = DrvLimitReset;  range_lim = MaxRangeReset;  home_bits = HomeMaskReset;
    srv_pos = '0;  srv_prev_err = '0;  srv_tgt = '0;  srv_home = '0;
    srv_limit = TravelLimReset;  srv_drive = '0;  srv_speed = '0;  srv_esum = 0;
    srv_en = 1'b0;  srv_hlev = 1'b0;  srv_homing = 1'b0;
  endfunction

  // apply one request to the model and queue the status it produces
  function automatic void advance_servo(servo_cmd_t c);
    logic [DataW-1:0]        err, derr, acc;
    logic signed [DataW-1:0] shifted;
    longint                  sum, drv;
    logic                    was_home;
    case (c.cmd)
      CMD_TICK: begin
        srv_speed = c.enc - srv_pos;
        srv_pos = c.enc;
        if (srv_en) begin
          err = srv_tgt - srv_pos;
          derr = err - srv_prev_err;
          // saturate the integral on the exact sum
          sum = longint'(srv_esum) + longint'($signed(err));
          if (sum > longint'(IntegralLimit)) sum = longint'(IntegralLimit);
          if (sum < -longint'(IntegralLimit)) sum = -longint'(IntegralLimit);
          srv_esum = int'(sum);
          acc = gain_kp * err + gain_ki * DataW'(srv_esum) + gain_kd * derr;
          shifted = $signed(acc) >>> 16;
          drv = shifted;
          if (drv > longint'(drive_lim)) drv = longint'(drive_lim);
          if (drv < -longint'(drive_lim)) drv = -longint'(drive_lim);
          srv_drive = drv[DataW-1:0];
          srv_prev_err = err;
        end else begin
          srv_esum = 0;
        end
        was_home = srv_hlev;
        srv_hlev = (c.sw & home_bits) != '0;
        if (!was_home && srv_hlev) begin
          srv_en = 1'b0;
          srv_drive = '0;
          if (srv_homing) begin
            srv_homing = 1'b0;
            srv_home = c.enc;
            srv_tgt = c.enc;
            srv_limit = c.enc + {1'b0, range_lim};
          end
        end
        if (srv_en && $signed(srv_pos) > $signed(srv_limit)) begin
          srv_en = 1'b0;
          srv_drive = '0;
        end
      end
      CMD_ENABLE: begin
        srv_drive = '0;
        srv_en = 1'b1;
      end
      CMD_DISABLE: begin
        srv_drive = '0;
        srv_en = 1'b0;
      end
      CMD_JUMP: begin
        if (srv_en) srv_tgt = c.rel + srv_home;
      end
      CMD_HOME: begin
        srv_en = 1'b0;
        srv_homing = 1'b1;
        srv_drive = HomingDrive;
      end
      default: ;
    endcase
    status_exp_q.push_back({5'b0, srv_speed, srv_pos - srv_home, srv_pos,
                            srv_homing, srv_hlev, srv_en, srv_drive});
  endfunction

  task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
    mismatches++;
    $display("mismatch on %s at result %0d: got %h, want %h", what, results_seen, got, want);
  endtask

  // sample side: config writes, result checks, accepted requests
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_servo_model();
      status_exp_q.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_KP:        gain_kp = cfg_wdata;
          REG_KI:        gain_ki = cfg_wdata;
          REG_KD:        gain_kd = cfg_wdata;
          REG_DRV_LIMIT: drive_lim = cfg_wdata[ClampW-1:0];
          REG_MAX_RANGE: range_lim = cfg_wdata[ClampW-1:0];
          REG_HOME_MASK: home_bits = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (status_exp_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[DataW-1:0], '0);
        end else begin
          want_bits = status_exp_q.pop_front();
          got_bits = out_tdata;
          for (int i = 0; i < NFields; i++) begin
            if ((DataW'(got_bits >> field_lsb[i]) & field_mask[i]) !=
                (DataW'(want_bits >> field_lsb[i]) & field_mask[i]))
              report_mismatch(field_name[i], DataW'(got_bits >> field_lsb[i]) & field_mask[i],
                              DataW'(want_bits >> field_lsb[i]) & field_mask[i]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        advance_servo('{cmd: in_tuser, enc: in_tdata[31:0], sw: in_tdata[63:32],
                        rel: in_tdata[95:64]});
        req_taken = 1'b1;
      end
    end
  end

  // drive side: present queued requests, stall the result channel
  always @(negedge clk) begin
    if (rst_n) begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= IdlePct);
      if (!in_tvalid || req_taken) begin
        req_taken = 1'b0;
        if (pending_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= IdlePct)) begin
          drv_req = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= drv_req.cmd;
          in_tdata  <= {drv_req.rel, drv_req.sw, drv_req.enc};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic push_req(logic [CmdW-1:0] cmd, logic [DataW-1:0] enc, logic [DataW-1:0] sw,
                          logic [DataW-1:0] rel);
    pending_q.push_back('{cmd: cmd, enc: enc, sw: sw, rel: rel});
    queued++;
  endtask

  task automatic push_tick(logic [DataW-1:0] enc, logic [DataW-1:0] sw);
    push_req(CMD_TICK, enc, sw, $urandom);
  endtask

  task automatic push_jump(logic [DataW-1:0] rel);
    push_req(CMD_JUMP, $urandom, $urandom, rel);
  endtask

  task automatic push_cmd(logic [CmdW-1:0] cmd);
    push_req(cmd, $urandom, $urandom, $urandom);
  endtask

  function automatic logic [DataW-1:0] sw_on();
    return $urandom | stim_mask;
  endfunction

  function automatic logic [DataW-1:0] sw_off();
    return $urandom & ~stim_mask;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [DataW-1:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic set_gains(logic [DataW-1:0] kp, logic [DataW-1:0] ki, logic [DataW-1:0] kd,
                           logic [DataW-1:0] clamp, logic [DataW-1:0] range,
                           logic [DataW-1:0] mask);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_DRV_LIMIT, clamp);
    write_reg(REG_MAX_RANGE, range);
    write_reg(REG_HOME_MASK, mask);
    stim_mask = mask;
  endtask

  // hold until every queued request is taken and every result is back
  task automatic wait_drain();
    while (pending_q.size() != 0 || in_tvalid || status_exp_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // mostly homing runs followed by servo moves, with some raw noise in between
  task automatic run_random(int n);
    int               stop, k;
    logic [DataW-1:0] pos;
    stop = queued + n;
    pos = $urandom;
    while (queued < stop) begin
      if ($urandom_range(0, 9) < 7) begin
        push_cmd(CMD_HOME);
        k = $urandom_range(0, 4);
        repeat (k) begin
          pos = pos - $urandom_range(0, 100);
          push_tick(pos, sw_off());
        end
        push_tick(pos, sw_on());
        if ($urandom_range(0, 1)) push_tick(pos, sw_on());
        push_cmd(CMD_ENABLE);
        k = $urandom_range(4, 24);
        repeat (k) begin
          case ($urandom_range(0, 19))
            0, 1, 2: push_jump($urandom_range(0, 4000) - 1000);
            3:       push_jump($urandom);
            4:       push_cmd($urandom_range(0, 1) ? CMD_ENABLE : CMD_DISABLE);
            5: begin
              pos = $urandom;
              push_tick(pos, $urandom);
            end
            default: begin
              pos = pos + $urandom_range(0, 300) - 120;
              push_tick(pos, sw_off());
            end
          endcase
        end
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) push_req(CmdW'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    stim_mask = HomeMaskReset;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed part under reset gains
    push_tick(32'd0, 32'd0);
    push_jump(32'd100);                       // ignored while disabled
    push_cmd(CMD_ENABLE);
    push_jump(32'd1000);
    push_tick(32'd10, 32'd0);                 // drive hits the clamp
    push_tick(32'h7fff_ffff, 32'hffff_fffe);  // past the travel limit
    push_cmd(CMD_ENABLE);
    push_jump(32'h8000_0000);
    push_tick(32'h8000_0000, 32'd0);
    push_jump(32'h7fff_ffff);
    push_tick(32'hffff_fffb, 32'd0);
    push_tick(32'hffff_fff0, 32'd0);
    push_cmd(CMD_HOME);
    push_tick(32'd300, 32'd0);
    push_tick(32'd200, 32'hffff_ffff);        // home edge latches home at 200
    push_tick(32'd200, 32'd1);                // level held, no edge
    push_cmd(CMD_ENABLE);
    push_jump(32'hffff_ffce);
    push_tick(32'd190, 32'd0);
    push_tick(32'd180, 32'd0);
    push_cmd(CMD_DISABLE);
    push_cmd(CMD_ENABLE);
    push_tick(32'd1737, 32'd0);               // one past home plus range
    push_cmd(CMD_RSV5);
    push_cmd(CMD_RSV6);
    push_cmd(CMD_RSV7);
    push_cmd(CMD_ENABLE);
    push_tick(32'd50, 32'd1);                 // home edge with no homing pending
    wait_drain();
    run_random(220);
    wait_drain();

    set_gains(32'h0000_4000, 32'h0000_0100, 32'h0002_0000, 32'd2000, 32'd4000, 32'h1);
    no_idle = 1'b1;
    run_random(220);
    wait_drain();
    no_idle = 1'b0;

    set_gains(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff);
    run_random(220);
    wait_drain();

    set_gains(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000);
    run_random(200);
    wait_drain();

    set_gains($urandom, $urandom, $urandom, $urandom_range(0, 4096), $urandom_range(0, 8000),
              32'd1 << $urandom_range(0, 31));
    run_random(220);
    wait_drain();

    set_gains(32'hfff0_0000, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'd100, 32'd0);
    run_random(200);
    wait_drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
